>>> src/pairwise_cosine_distance_defines.svh
// assertion macros for the pairwise cosine distance block
`ifndef PAIRWISE_COSINE_DISTANCE_DEFINES_SVH
`define PAIRWISE_COSINE_DISTANCE_DEFINES_SVH

// whenever a holds, b must hold in the same cycle
`define PCD_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pcd check failed");

// whenever a holds, b must hold in the next cycle
`define PCD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pcd sequence check failed");

`endif

>>> src/pcd_pkg.sv
// shared constants, config struct and width helpers for the cosine distance block
`timescale 1ns / 1ps
`default_nettype none
package pcd_pkg;

  localparam int DEF_MAX_VECTORS = 64;
  localparam int DEF_MAX_DIM     = 64;
  localparam int CFG_W           = 7;
  localparam int IDX_W           = 6;
  localparam int DIST_W          = 18;
  localparam logic [DIST_W-1:0] DIST_LIMIT = 18'd131072;
  // quotient bits produced by the serial divider
  localparam int QUOT_BITS       = 20;
  localparam int FIFO_DEPTH      = 4;

  // register indexes
  localparam logic CFG_VECTOR_COUNT = 1'b0;
  localparam logic CFG_DIMENSION    = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] vector_count;
    logic [CFG_W-1:0] dimension;
  } pcd_cfg_t;

  // square sum of one vector
  function automatic int sq_width(int max_dim);
    return 31 + $clog2(max_dim);
  endfunction

  // signed dot product
  function automatic int dot_width(int max_dim);
    return 32 + $clog2(max_dim);
  endfunction

  // norm with 8 fraction bits
  function automatic int norm_width(int max_dim);
    return (sq_width(max_dim) + 17) / 2;
  endfunction

endpackage
`default_nettype wire

>>> src/pcd_ram.sv
// generic single write, single read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module pcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/pcd_fifo.sv
// short pair queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module pcd_fifo
  import pcd_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/pcd_front.sv
// front part: takes components, updates dot products, computes norms, queues pairs
`timescale 1ns / 1ps
`default_nettype none
module pcd_front
  import pcd_pkg::*;
#(
  parameter int MAX_VECTORS = DEF_MAX_VECTORS,
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int QW          = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pcd_cfg_t           cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] component,
  output logic                    push,
  output logic [QW-1:0]           push_data,
  input  wire logic               q_full
);

  localparam int VW     = $clog2(MAX_VECTORS);
  localparam int CW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int VDEPTH = MAX_VECTORS * MAX_DIM;
  localparam int VAW    = $clog2(VDEPTH);
  localparam int SQ_W   = sq_width(MAX_DIM);
  localparam int DOT_W  = dot_width(MAX_DIM);
  localparam int NORM_W = norm_width(MAX_DIM);
  localparam int RAD_W  = 2 * NORM_W;
  localparam int NCW    = $clog2(NORM_W + 1);
  localparam int DCW    = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int VCW    = 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DOT   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_NWR   = 3'd4;
  localparam logic [2:0] S_PRD   = 3'd5;
  localparam logic [2:0] S_PPUSH = 3'd6;
  localparam logic [2:0] S_END   = 3'd7;

  logic [2:0]               state;
  logic [CW-1:0]            c;
  logic [VW-1:0]            v;
  logic [VAW-1:0]           wr_base;
  logic [VAW-1:0]           rd_base;
  logic [VW-1:0]            issue_i;
  logic signed [15:0]       x_reg;
  logic                     v1;
  logic                     v2;
  logic [VW-1:0]            i1;
  logic [VW-1:0]            i2;
  logic signed [31:0]       prod;
  logic signed [DOT_W-1:0]  dsrc;
  logic [SQ_W-1:0]          sq_sum;
  logic signed [31:0]       sq_prod;
  logic [RAD_W-1:0]         rad;
  logic [NORM_W-1:0]        root;
  logic [NORM_W:0]          rem;
  logic [NORM_W+2:0]        rem_sh;
  logic [NORM_W+2:0]        trial;
  logic [NCW-1:0]           ncnt;
  logic [NORM_W-1:0]        nj;
  logic [VW-1:0]            pi;
  logic                     accept;
  logic                     issue;
  logic                     vec_end;
  logic                     set_end;
  logic [15:0]              vec_rdata;
  logic [DOT_W-1:0]         dot_rdata;
  logic [NORM_W-1:0]        norm_rdata;
  logic [VW-1:0]            dot_raddr;
  logic signed [DOT_W-1:0]  dot_wdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign issue    = (state == S_DOT) && (issue_i < v);
  assign sq_prod  = component * component;

  // vector and set end tests, out of range registers act as clamped
  assign vec_end = (DCW'(c) + 1'b1 >= DCW'(cfg.dimension)) ||
                   (DCW'(c) + 1'b1 >= DCW'(MAX_DIM));
  assign set_end = (VCW'(v) + 1'b1 >= VCW'(cfg.vector_count)) ||
                   (VCW'(v) + 1'b1 >= VCW'(MAX_VECTORS));

  // one digit pair of the integer square root
  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = (NORM_W+3)'({root, 2'b01});

  // stores
  pcd_ram #(.WIDTH(16), .DEPTH(VDEPTH)) u_vec_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_base + VAW'(c)),
    .wdata (component),
    .raddr (rd_base + VAW'(c)),
    .rdata (vec_rdata)
  );

  assign dot_raddr = (state == S_DOT) ? issue_i : pi;
  assign dot_wdata = dsrc + DOT_W'(prod);

  pcd_ram #(.WIDTH(DOT_W), .DEPTH(MAX_VECTORS)) u_dot_ram (
    .clk   (clk),
    .we    (v2),
    .waddr (i2),
    .wdata (dot_wdata),
    .raddr (dot_raddr),
    .rdata (dot_rdata)
  );

  pcd_ram #(.WIDTH(NORM_W), .DEPTH(MAX_VECTORS)) u_norm_ram (
    .clk   (clk),
    .we    (state == S_NWR),
    .waddr (v),
    .wdata (root),
    .raddr (pi),
    .rdata (norm_rdata)
  );

  // pair word to the queue
  assign push      = (state == S_PPUSH) && !q_full;
  assign push_data = {pi, v, dot_rdata, norm_rdata, nj, (pi + 1'b1 == v)};

  // multiply pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg <= component;
    end
    if (v1) begin
      prod <= x_reg * $signed(vec_rdata);
      dsrc <= (c == '0) ? '0 : $signed(dot_rdata);
    end
    i1 <= issue_i;
    i2 <= i1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      c       <= '0;
      v       <= '0;
      wr_base <= '0;
      rd_base <= '0;
      issue_i <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      sq_sum  <= '0;
      pi      <= '0;
      ncnt    <= '0;
      rad     <= '0;
      root    <= '0;
      rem     <= '0;
      nj      <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      case (state)
        S_IDLE: begin
          if (accept) begin
            sq_sum  <= ((c == '0) ? '0 : sq_sum) + SQ_W'($unsigned(sq_prod));
            issue_i <= '0;
            rd_base <= '0;
            state   <= (v != '0) ? S_DOT : S_CHK;
          end
        end
        S_DOT: begin
          if (issue) begin
            issue_i <= issue_i + 1'b1;
            rd_base <= rd_base + VAW'(MAX_DIM);
          end else if (!v1 && !v2) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (vec_end) begin
            rad   <= RAD_W'({sq_sum, 16'b0});
            root  <= '0;
            rem   <= '0;
            ncnt  <= NCW'(NORM_W);
            state <= S_NORM;
          end else begin
            c     <= c + 1'b1;
            state <= S_IDLE;
          end
        end
        S_NORM: begin
          rad <= rad << 2;
          if (rem_sh >= trial) begin
            rem  <= (NORM_W+1)'(rem_sh - trial);
            root <= {root[NORM_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh[NORM_W:0];
            root <= {root[NORM_W-2:0], 1'b0};
          end
          ncnt <= ncnt - 1'b1;
          if (ncnt == NCW'(1)) begin
            state <= S_NWR;
          end
        end
        S_NWR: begin
          nj    <= root;
          pi    <= '0;
          state <= (v == '0) ? S_END : S_PRD;
        end
        S_PRD: begin
          state <= S_PPUSH;
        end
        S_PPUSH: begin
          if (!q_full) begin
            if (pi + 1'b1 == v) begin
              state <= S_END;
            end else begin
              pi    <= pi + 1'b1;
              state <= S_PRD;
            end
          end
        end
        S_END: begin
          c <= '0;
          if (set_end) begin
            v       <= '0;
            wr_base <= '0;
          end else begin
            v       <= v + 1'b1;
            wr_base <= wr_base + VAW'(MAX_DIM);
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/pcd_back.sv
// back part: turns one queued pair into a rounded, clamped distance
`timescale 1ns / 1ps
`default_nettype none
module pcd_back
  import pcd_pkg::*;
#(
  parameter int MAX_VECTORS = DEF_MAX_VECTORS,
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int QW          = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  output logic                   pop,
  input  wire logic [QW-1:0]     pop_data,
  input  wire logic              q_empty,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [IDX_W-1:0]       row_index,
  output logic [IDX_W-1:0]       col_index,
  output logic [DIST_W-1:0]      distance,
  output logic                   zero_norm,
  output logic                   last
);

  localparam int VW     = $clog2(MAX_VECTORS);
  localparam int DOT_W  = dot_width(MAX_DIM);
  localparam int NORM_W = norm_width(MAX_DIM);
  localparam int PW     = 2 * NORM_W;
  localparam int MW     = DOT_W + 18;
  localparam int NW     = MW + 17;
  localparam int QCW    = $clog2(QUOT_BITS + 1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_SUB  = 3'd2;
  localparam logic [2:0] B_PREP = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_FIN  = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  logic [2:0]               state;
  logic [VW-1:0]            row_r;
  logic [VW-1:0]            col_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [NORM_W-1:0]        ni_r;
  logic [NORM_W-1:0]        nj_r;
  logic                     last_r;
  logic                     zero_r;
  logic [PW-1:0]            p_r;
  logic signed [MW-1:0]     m_r;
  logic [NW-1:0]            n_full;
  logic [NW-1:0]            r0_ext;
  logic [PW:0]              d_val;
  logic [PW:0]              r;
  logic [PW+1:0]            rs;
  logic [QUOT_BITS-1:0]     low;
  logic [QUOT_BITS-1:0]     q;
  logic [QCW-1:0]           qcnt;
  logic [DIST_W-1:0]        dist_r;

  assign pop    = (state == B_IDLE) && !q_empty;
  assign d_val  = {p_r, 1'b0};
  assign n_full = (NW'($unsigned(m_r)) << 17) + NW'(p_r);
  assign r0_ext = n_full >> QUOT_BITS;
  assign rs     = {r, low[QUOT_BITS-1]};

  // pair payload and arithmetic registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        {row_r, col_r, dot_r, ni_r, nj_r, last_r} <= pop_data;
      end
      B_MUL: begin
        p_r    <= ni_r * nj_r;
        zero_r <= (ni_r == '0) || (nj_r == '0);
      end
      B_SUB: begin
        m_r <= $signed(MW'(p_r)) - ($signed(MW'(dot_r)) <<< 16);
      end
      B_PREP: begin
        r    <= (PW+1)'(r0_ext);
        low  <= n_full[QUOT_BITS-1:0];
        q    <= '0;
        qcnt <= QCW'(QUOT_BITS);
        if (zero_r || m_r[MW-1] || (m_r == '0)) begin
          dist_r <= '0;
        end else if (r0_ext >= NW'(d_val)) begin
          dist_r <= DIST_LIMIT;
        end
      end
      B_DIV: begin
        // one restoring step per cycle
        low  <= low << 1;
        qcnt <= qcnt - 1'b1;
        if (rs >= {1'b0, d_val}) begin
          r <= (PW+1)'(rs - {1'b0, d_val});
          q <= {q[QUOT_BITS-2:0], 1'b1};
        end else begin
          r <= rs[PW:0];
          q <= {q[QUOT_BITS-2:0], 1'b0};
        end
      end
      B_FIN: begin
        dist_r <= (q > QUOT_BITS'(DIST_LIMIT)) ? DIST_LIMIT : q[DIST_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_MUL;
          end
        end
        B_MUL: state <= B_SUB;
        B_SUB: state <= B_PREP;
        B_PREP: begin
          if (zero_r || m_r[MW-1] || (m_r == '0) || (r0_ext >= NW'(d_val))) begin
            state <= B_DONE;
          end else begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (qcnt == QCW'(1)) begin
            state <= B_FIN;
          end
        end
        B_FIN: state <= B_DONE;
        B_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == B_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_DONE) && (!out_valid || !out_stall)) begin
      row_index <= IDX_W'(row_r);
      col_index <= IDX_W'(col_r);
      distance  <= dist_r;
      zero_norm <= zero_r;
      last      <= last_r;
    end
  end

endmodule
`default_nettype wire

>>> src/pairwise_cosine_distance.sv
// top level of the streaming pairwise cosine distance block
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid / in_stall    | component
//  out     | output    | out_valid / out_stall  | row_index col_index distance zero_norm last
//  cfg     | input     | cfg_write              | cfg_index cfg_data
//
// a component's dot product update walks the earlier vectors (one shared
// multiplier), which vector 0 skips; the last component of a vector adds the
// integer square root of its norm and the queueing of one pair per earlier vector.
// each pair then goes through the serial divider of the back part.
// rst is synchronous and needs no clearing pass; out_stall backs up into the
// pair queue and then holds in_stall high.
`timescale 1ns / 1ps
`default_nettype none
`include "pairwise_cosine_distance_defines.svh"
module pairwise_cosine_distance
  import pcd_pkg::*;
#(
  parameter int MAX_VECTORS = DEF_MAX_VECTORS,
  parameter int MAX_DIM     = DEF_MAX_DIM
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] component,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [IDX_W-1:0]        row_index,
  output logic [IDX_W-1:0]        col_index,
  output logic [DIST_W-1:0]       distance,
  output logic                    zero_norm,
  output logic                    last
);

  localparam int VW     = $clog2(MAX_VECTORS);
  localparam int DOT_W  = dot_width(MAX_DIM);
  localparam int NORM_W = norm_width(MAX_DIM);
  localparam int QW     = 2 * VW + DOT_W + 2 * NORM_W + 1;

  pcd_cfg_t        cfg;
  logic            push;
  logic [QW-1:0]   push_data;
  logic            pop;
  logic [QW-1:0]   pop_data;
  logic            q_full;
  logic            q_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vector_count <= CFG_W'(64);
      cfg.dimension    <= CFG_W'(64);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_VECTOR_COUNT: cfg.vector_count <= cfg_data;
        CFG_DIMENSION:    cfg.dimension    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pcd_front #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM), .QW(QW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .component (component),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  pcd_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  pcd_back #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM), .QW(QW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_empty   (q_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_index (row_index),
    .col_index (col_index),
    .distance  (distance),
    .zero_norm (zero_norm),
    .last      (last)
  );

  // result checks
  `PCD_ASSERT_IMPLY(a_dist_limit, clk, rst, out_valid, distance <= DIST_LIMIT)
  `PCD_ASSERT_IMPLY(a_zero_dist, clk, rst, out_valid && zero_norm, distance == '0)
  `PCD_ASSERT_IMPLY(a_pair_order, clk, rst, out_valid, row_index < col_index)
  `PCD_ASSERT_IMPLY(a_last_pair, clk, rst, out_valid && last,
                    ({1'b0, row_index} + 7'd1) == {1'b0, col_index})

endmodule
`default_nettype wire
